// ----- design/kplock_pkg.sv -----
`timescale 1ns / 1ps
// kplock_pkg: shared types, codes and sizes for the keypad PIN lock.
package kplock_pkg;

	// Digit buffer sizing: one slot is kept back, as the buffer holds DIGIT_SLOTS-1 digits
	localparam int DIGIT_SLOTS = 32;
	localparam int STORE_DEPTH = DIGIT_SLOTS - 1;
	localparam int COUNT_W     = $clog2(DIGIT_SLOTS);
	localparam int DIGIT_W     = 4;
	localparam int PIN_BITS    = DIGIT_W * STORE_DEPTH;

	localparam int PIN_LOW_W   = 64;
	localparam int PIN_HIGH_W  = 60;
	localparam int TIMEOUT_W   = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [COUNT_W-1:0]   PIN_LENGTH_RST = COUNT_W'(4);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = TIMEOUT_W'(300000);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_HIGH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd3;

	// Action codes
	localparam logic [2:0] ACT_KEY         = 3'd0;
	localparam logic [2:0] ACT_PIN_ENTRY   = 3'd1;
	localparam logic [2:0] ACT_LOCK        = 3'd2;
	localparam logic [2:0] ACT_SCREEN_LOCK = 3'd3;
	localparam logic [2:0] ACT_TICK        = 3'd4;

	// Indicator codes
	localparam logic [1:0] IND_LOCKED   = 2'd0;
	localparam logic [1:0] IND_ENTERING = 2'd1;
	localparam logic [1:0] IND_UNLOCKED = 2'd2;

	// HID usage codes
	localparam logic [7:0] KEY_1     = 8'h1E;
	localparam logic [7:0] KEY_9     = 8'h26;
	localparam logic [7:0] KEY_0     = 8'h27;
	localparam logic [7:0] KEY_ENTER = 8'h28;
	localparam logic [7:0] KEY_ESC   = 8'h29;
	localparam logic [7:0] KP_ENTER  = 8'h58;
	localparam logic [7:0] KP_1      = 8'h59;
	localparam logic [7:0] KP_9      = 8'h61;
	localparam logic [7:0] KP_0      = 8'h62;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] key_code;
	} item_t;

	typedef struct packed {
		logic       consumed;
		logic [1:0] indicator;
		logic       unlocked_flag;
		logic       pin_accepted;
		logic       pin_rejected;
	} result_t;

endpackage

// ----- design/keypad_pin_lock_timeout_top.sv -----
`timescale 1ns / 1ps
// keypad_pin_lock_timeout_top: keypad PIN lock with auto relock after a tick timeout.
//
// Channel  | Handshake                 | Word
// ---------+---------------------------+-----------------------------------------
// item     | item_valid / item_stall   | item_t   : action, key_code
// result   | result_valid / result_stall | result_t : consumed, indicator, flags
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data (64 bits)
//
// One word in per cycle and one result word out per cycle while result_stall is low;
// each word passes the input register, then the result register.
// Each word is processed from the input register into the result
// register, updating the lock state on the same edge.
// A stalled result holds the input register, and item_stall then rises.
// arst_n clears lock state, counters and valid bits; the digit buffer is not cleared,
// as only digits written during the current entry are compared. cfg_ready is always
// high; the user must write the registers only while the lock is idle (not enforced).
module keypad_pin_lock_timeout_top import kplock_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [COUNT_W-1:0]    pin_length_q;
	logic [PIN_LOW_W-1:0]  pin_low_q;
	logic [PIN_HIGH_W-1:0] pin_high_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [PIN_BITS-1:0]   pin_code;

	// lock state
	logic                 unlocked_q;
	logic                 entry_q;
	logic [COUNT_W-1:0]   count_q;
	logic [TIMEOUT_W-1:0] ticks_q;
	logic [DIGIT_W-1:0]   store_q [STORE_DEPTH];

	// pipeline
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    advance;

	// next-state logic
	logic                 unlocked_d;
	logic                 entry_d;
	logic [COUNT_W-1:0]   count_d;
	logic [TIMEOUT_W-1:0] ticks_d;
	logic [TIMEOUT_W-1:0] ticks_inc;
	logic                 store_we;
	logic [DIGIT_W-1:0]   digit_val;
	logic                 digit_ok;
	logic [STORE_DEPTH-1:0] digit_hit;
	logic                 pin_match;
	result_t              result_d;

	assign cfg_ready = 1'b1;
	assign pin_code  = {pin_high_q, pin_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_length_q <= PIN_LENGTH_RST;
			pin_low_q    <= '0;
			pin_high_q   <= '0;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIN_LENGTH: pin_length_q <= cfg_data[COUNT_W-1:0];
				CFG_PIN_LOW:    pin_low_q    <= cfg_data;
				CFG_PIN_HIGH:   pin_high_q   <= cfg_data[PIN_HIGH_W-1:0];
				CFG_TIMEOUT:    timeout_q    <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 moves on when the result register is free or draining
	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// key decode: main row and keypad digits
	always_comb begin
		digit_ok  = 1'b1;
		digit_val = '0;
		case (item_s1.key_code) inside
			[KEY_1:KEY_9]: digit_val = DIGIT_W'(item_s1.key_code - KEY_1 + 8'd1);
			[KP_1:KP_9]:   digit_val = DIGIT_W'(item_s1.key_code - KP_1 + 8'd1);
			KEY_0, KP_0:   digit_val = '0;
			default:       digit_ok  = 1'b0;
		endcase
	end

	// PIN compare over the digits typed so far; later slots are masked off
	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			digit_hit[i] = (COUNT_W'(i) >= count_q) ||
			               (store_q[i] == pin_code[DIGIT_W*i +: DIGIT_W]);
		end
	end

	assign pin_match = (count_q == pin_length_q) && (&digit_hit);
	assign ticks_inc = (&ticks_q) ? ticks_q : ticks_q + TIMEOUT_W'(1);

	always_comb begin
		unlocked_d = unlocked_q;
		entry_d    = entry_q;
		count_d    = count_q;
		ticks_d    = ticks_q;
		store_we   = 1'b0;
		result_d   = '0;
		case (item_s1.action)
			ACT_KEY: begin
				if (entry_q) begin
					if (digit_ok) begin
						// full buffer drops the digit but still swallows it
						if (count_q < COUNT_W'(STORE_DEPTH)) begin
							store_we = 1'b1;
							count_d  = count_q + COUNT_W'(1);
						end
						result_d.consumed = 1'b1;
					end else if (item_s1.key_code == KEY_ENTER ||
					             item_s1.key_code == KP_ENTER) begin
						if (pin_match) begin
							unlocked_d            = 1'b1;
							ticks_d               = '0;
							result_d.pin_accepted = 1'b1;
						end else begin
							result_d.pin_rejected = 1'b1;
						end
						entry_d           = 1'b0;
						count_d           = '0;
						result_d.consumed = 1'b1;
					end else if (item_s1.key_code == KEY_ESC) begin
						entry_d           = 1'b0;
						count_d           = '0;
						result_d.consumed = 1'b1;
					end
				end
			end
			ACT_PIN_ENTRY: begin
				// toggles: start entry when locked, lock when unlocked
				if (!unlocked_q) begin
					entry_d = 1'b1;
					count_d = '0;
				end else begin
					unlocked_d = 1'b0;
					entry_d    = 1'b0;
					count_d    = '0;
				end
				result_d.consumed = 1'b1;
			end
			ACT_LOCK: begin
				unlocked_d = 1'b0;
				entry_d    = 1'b0;
				count_d    = '0;
			end
			ACT_SCREEN_LOCK: begin
				unlocked_d = 1'b0;
			end
			ACT_TICK: begin
				ticks_d = ticks_inc;
				if (unlocked_q && (ticks_inc > timeout_q)) begin
					unlocked_d = 1'b0;
					entry_d    = 1'b0;
					count_d    = '0;
				end
			end
			default: ;
		endcase
		result_d.unlocked_flag = unlocked_d;
		result_d.indicator     = entry_d ? IND_ENTERING :
		                         (unlocked_d ? IND_UNLOCKED : IND_LOCKED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlocked_q <= 1'b0;
			entry_q    <= 1'b0;
			count_q    <= '0;
			ticks_q    <= '0;
		end else if (advance) begin
			unlocked_q <= unlocked_d;
			entry_q    <= entry_d;
			count_q    <= count_d;
			ticks_q    <= ticks_d;
		end
	end

	// digit buffer, written at the current fill position
	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			store_q[count_q] <= digit_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(STORE_DEPTH))
		else $error("digit count past buffer depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!entry_q |-> (count_q == '0))
		else $error("digits held outside PIN entry");

	a_accept_unlocks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result_d.pin_accepted) |=> (unlocked_q && ticks_q == '0))
		else $error("accepted PIN did not unlock");

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.pin_accepted && result_s2.pin_rejected))
		else $error("accept and reject in one result");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for the keypad PIN lock, with a lock model and random traffic.
module tb_top;
	import kplock_pkg::*;

	// Cycles with no word moving on any channel before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// Eight configuration phases of this many live words each
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 175;
	// Letter keys: never digits, Enter or Escape
	localparam logic [7:0] KEY_A = 8'h04;
	localparam logic [7:0] KEY_Z = 8'h1D;

	typedef enum int {TRY_GOOD, TRY_BAD_DIGIT, TRY_BAD_LENGTH, TRY_OVERFLOW, TRY_ESC} attempt_t;

	// Lock model plus the queue of results still owed by the block
	class lock_scoreboard;
		logic [COUNT_W-1:0]    pin_len;
		logic [PIN_LOW_W-1:0]  pin_lo;
		logic [PIN_HIGH_W-1:0] pin_hi;
		logic [TIMEOUT_W-1:0]  timeout;
		bit                    is_unlocked;
		bit                    entering;
		int unsigned           n_digits;
		logic [DIGIT_W-1:0]    digits[STORE_DEPTH];
		logic [TIMEOUT_W-1:0]  ticks;
		result_t               owed[$];
		int unsigned           errors;

		function new();
			pin_len     = PIN_LENGTH_RST;
			pin_lo      = '0;
			pin_hi      = '0;
			timeout     = TIMEOUT_RST;
			is_unlocked = 0;
			entering    = 0;
			n_digits    = 0;
			ticks       = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PIN_LENGTH: pin_len = data[COUNT_W-1:0];
				CFG_PIN_LOW:    pin_lo  = data[PIN_LOW_W-1:0];
				CFG_PIN_HIGH:   pin_hi  = data[PIN_HIGH_W-1:0];
				CFG_TIMEOUT:    timeout = data[TIMEOUT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [DIGIT_W-1:0] pin_digit(int i);
			if (i < 16)
				return pin_lo[DIGIT_W*i +: DIGIT_W];
			return pin_hi[DIGIT_W*(i-16) +: DIGIT_W];
		endfunction

		// Digit value of a key, or -1
		function int key_digit(logic [7:0] k);
			if (k >= KEY_1 && k <= KEY_9) return int'(k - KEY_1) + 1;
			if (k == KEY_0) return 0;
			if (k >= KP_1 && k <= KP_9) return int'(k - KP_1) + 1;
			if (k == KP_0) return 0;
			return -1;
		endfunction

		function bit pin_ok();
			if (n_digits != pin_len) return 0;
			for (int i = 0; i < n_digits; i++)
				if (digits[i] != pin_digit(i)) return 0;
			return 1;
		endfunction

		function void relock();
			is_unlocked = 0;
			entering    = 0;
			n_digits    = 0;
		endfunction

		// Advance the lock by one accepted word; queue and return what it must answer
		function result_t take_word(item_t w);
			result_t exp;
			int d;
			exp = '0;
			case (w.action)
				ACT_KEY: if (entering) begin
					d = key_digit(w.key_code);
					if (d >= 0) begin
						if (n_digits < STORE_DEPTH) begin
							digits[n_digits] = DIGIT_W'(d);
							n_digits++;
						end
						exp.consumed = 1;
					end else if (w.key_code == KEY_ENTER || w.key_code == KP_ENTER) begin
						if (pin_ok()) begin
							is_unlocked      = 1;
							ticks            = '0;
							exp.pin_accepted = 1;
						end else begin
							exp.pin_rejected = 1;
						end
						entering     = 0;
						n_digits     = 0;
						exp.consumed = 1;
					end else if (w.key_code == KEY_ESC) begin
						entering     = 0;
						n_digits     = 0;
						exp.consumed = 1;
					end
				end
				ACT_PIN_ENTRY: begin
					if (!is_unlocked) begin
						entering = 1;
						n_digits = 0;
					end else begin
						relock();
					end
					exp.consumed = 1;
				end
				ACT_LOCK:        relock();
				ACT_SCREEN_LOCK: is_unlocked = 0;
				ACT_TICK: begin
					if (ticks != '1) ticks++;
					if (is_unlocked && ticks > timeout) relock();
				end
				default: ;
			endcase
			exp.indicator     = entering ? IND_ENTERING : (is_unlocked ? IND_UNLOCKED : IND_LOCKED);
			exp.unlocked_flag = is_unlocked;
			owed.push_back(exp);
			return exp;
		endfunction

		function void check_field(string name, logic [1:0] want, logic [1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				$display("%0t: result %p with nothing expected", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			check_field("consumed",      want.consumed,      got.consumed);
			check_field("indicator",     want.indicator,     got.indicator);
			check_field("unlocked_flag", want.unlocked_flag, got.unlocked_flag);
			check_field("pin_accepted",  want.pin_accepted,  got.pin_accepted);
			check_field("pin_rejected",  want.pin_rejected,  got.pin_rejected);
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lock_scoreboard sb;
	bit             steady;      // no input gaps for the current sequence
	int             live_words;  // words of the current phase that the lock acts on
	int             idle_cycles;
	int             calm_left;
	int             stall_left;

	keypad_pin_lock_timeout_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Result side: alternate calm stretches with stalls, mostly short, now and then long
	initial begin
		result_stall = 0;
		calm_left    = 0;
		stall_left   = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_stall = 1;
				stall_left--;
			end else if (calm_left > 0) begin
				result_stall = 0;
				calm_left--;
			end else begin
				result_stall = 0;
				calm_left  = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 80)
				                                          : $urandom_range(0, 4);
				stall_left = $urandom_range(0, 99);
				stall_left = (stall_left < 85) ? $urandom_range(1, 3) :
				             (stall_left < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
			end
		end
	end

	// Every accepted result is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// Watchdog: gives up once nothing has moved for too long
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Entered and left just after a falling edge; valid stays up when no gap follows
	task automatic push_word(input logic [2:0] act, input logic [7:0] key);
		int      gap;
		result_t exp;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid = 0;
			repeat (gap) @(negedge clk);
		end
		item_valid    = 1;
		item.action   = act;
		item.key_code = key;
		do @(posedge clk); while (item_stall);
		exp = sb.take_word(item);
		// ignored words (reserved actions, stray keys) do not count towards the phase
		if (act <= ACT_TICK && !(act == ACT_KEY && !exp.consumed))
			live_words++;
		@(negedge clk);
	endtask

	// Drop valid and wait for the block to drain before touching its registers
	task automatic quiesce();
		item_valid = 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_bcd();
		logic [63:0] v;
		for (int i = 0; i < 16; i++) v[4*i +: 4] = $urandom_range(0, 9);
		return v;
	endfunction

	function automatic logic [7:0] digit_code(int d, bit keypad);
		if (d == 0) return keypad ? KP_0 : KEY_0;
		return keypad ? 8'(KP_1 + d - 1) : 8'(KEY_1 + d - 1);
	endfunction

	// Digit to type at position i for the stored PIN; an unmatchable nibble gets any digit
	function automatic int typed_digit(int i);
		logic [DIGIT_W-1:0] nib;
		nib = sb.pin_digit(i);
		return (nib > 9) ? $urandom_range(0, 9) : int'(nib);
	endfunction

	// Settings per phase: lengths 0, 1, 4, 16, 17, 31 and random; timeouts 0, 1, small,
	// reset value and all ones; PINs in BCD, with bad nibbles, all nines and all ones
	task automatic configure_phase(input int phase);
		logic [63:0] len_w, lo, hi, to;
		len_w = 64'(4);
		lo    = rand_bcd();
		hi    = rand_bcd();
		to    = 64'(3);
		case (phase)
			1: begin len_w = 64'(1);  to = 64'(0); end
			2: begin len_w = 64'(31); to = 64'hFFFF_FFFF; end
			3: begin
				// empty PIN; junk above the length field must be dropped
				len_w = {$urandom, $urandom} & ~64'h1F;
				to    = 64'(1);
			end
			4: begin
				len_w = 64'($urandom_range(1, 31));
				lo    = {$urandom, $urandom};
				hi    = {$urandom, $urandom};
				to    = {$urandom, 32'($urandom_range(0, 15))};
			end
			5: begin len_w = 64'(16); to = 64'(2); end
			6: begin len_w = 64'(17); lo = '1; hi = '1; to = 64'(0); end
			7: begin len_w = 64'(31); lo = {16{4'h9}}; hi = {16{4'h9}}; to = 64'(TIMEOUT_RST); end
			default: ;
		endcase
		write_reg(CFG_PIN_LENGTH, len_w);
		write_reg(CFG_PIN_LOW, lo);
		write_reg(CFG_PIN_HIGH, hi);
		write_reg(CFG_TIMEOUT, to);
		cfg_valid = 0;
	endtask

	task automatic pin_attempt(input attempt_t flavour);
		int n, wrong_at, d;
		push_word(ACT_PIN_ENTRY, 8'($urandom));
		case (flavour)
			TRY_BAD_LENGTH:
				n = (sb.pin_len == 0 || $urandom_range(0, 1)) ? sb.pin_len + 1 : sb.pin_len - 1;
			TRY_OVERFLOW:   n = $urandom_range(STORE_DEPTH, STORE_DEPTH + 5);
			TRY_ESC:        n = $urandom_range(0, sb.pin_len);
			default:        n = sb.pin_len;
		endcase
		wrong_at = (n > 0) ? $urandom_range(0, n - 1) : 0;
		for (int i = 0; i < n; i++) begin
			d = (i < STORE_DEPTH) ? typed_digit(i) : $urandom_range(0, 9);
			if (flavour == TRY_BAD_DIGIT && i == wrong_at)
				d = (d + $urandom_range(1, 9)) % 10;
			// stray letters and ticks mid-entry must not disturb it
			if ($urandom_range(0, 11) == 0)
				push_word(ACT_KEY, 8'(KEY_A + $urandom_range(0, KEY_Z - KEY_A)));
			if ($urandom_range(0, 15) == 0)
				push_word(ACT_TICK, 8'($urandom));
			push_word(ACT_KEY, digit_code(d, $urandom_range(0, 1)));
		end
		if (flavour == TRY_ESC)
			push_word(ACT_KEY, KEY_ESC);
		else
			push_word(ACT_KEY, $urandom_range(0, 1) ? KEY_ENTER : KP_ENTER);
	endtask

	initial begin
		int r;
		sb         = new();
		arst_n     = 0;
		item_valid = 0;
		item       = '0;
		cfg_valid  = 0;
		cfg_index  = CFG_PIN_LENGTH;
		cfg_data   = '0;
		steady     = 0;
		live_words = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// Directed: reset PIN is four zeros
		push_word(ACT_KEY, KEY_1);            // locked, not in entry: passes through
		push_word(ACT_PIN_ENTRY, 8'h00);
		push_word(ACT_KEY, KEY_0);            // main-row zero is digit 0
		push_word(ACT_KEY, KP_0);
		push_word(ACT_KEY, KEY_0);
		push_word(ACT_KEY, KP_0);
		push_word(ACT_KEY, KEY_ENTER);        // match: unlock
		push_word(ACT_KEY, KEY_A);            // unlocked, not in entry: passes through
		push_word(ACT_TICK, 8'hFF);
		push_word(ACT_TICK, 8'h00);           // well under the reset timeout
		push_word(ACT_SCREEN_LOCK, 8'hA5);
		push_word(ACT_PIN_ENTRY, 8'h5A);
		push_word(ACT_KEY, KEY_9);
		push_word(ACT_KEY, KEY_ESC);          // cancel
		push_word(ACT_PIN_ENTRY, 8'h00);
		push_word(ACT_KEY, KP_9);
		push_word(ACT_KEY, KEY_A);            // other key in entry: not swallowed
		push_word(ACT_KEY, KP_ENTER);         // wrong PIN
		for (int a = int'(ACT_TICK) + 1; a < 8; a++)
			push_word(3'(a), 8'($urandom));   // reserved actions are ignored
		push_word(ACT_PIN_ENTRY, 8'h00);
		push_word(ACT_SCREEN_LOCK, 8'h00);    // entry survives a screen lock
		push_word(ACT_LOCK, 8'hFF);

		// Random phases, each under its own settings
		for (int phase = 0; phase < PHASES; phase++) begin
			quiesce();
			configure_phase(phase);
			live_words = 0;
			while (live_words < PHASE_WORDS) begin
				steady = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 45)      pin_attempt(TRY_GOOD);
				else if (r < 55) pin_attempt(TRY_BAD_DIGIT);
				else if (r < 62) pin_attempt(TRY_BAD_LENGTH);
				else if (r < 68) pin_attempt(TRY_OVERFLOW);
				else if (r < 74) pin_attempt(TRY_ESC);
				else if (r < 86) begin
					repeat ($urandom_range(1, 8)) push_word(ACT_TICK, 8'($urandom));
				end else if (r < 92) begin
					case ($urandom_range(0, 2))
						0:       push_word(ACT_LOCK, 8'($urandom));
						1:       push_word(ACT_SCREEN_LOCK, 8'($urandom));
						default: push_word(ACT_PIN_ENTRY, 8'($urandom));
					endcase
				end else begin
					repeat ($urandom_range(1, 4)) push_word(3'($urandom), 8'($urandom));
				end
			end
		end

		quiesce();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
